// ----- hdl/uer_pkg.sv -----
package uer_pkg;

    localparam int TRIG_LOW_TICKS_DEF  = 2;
    localparam int TRIG_HIGH_TICKS_DEF = 10;

    localparam int CNT_W   = 17;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 12;
    localparam int STAT_W  = 3;
    localparam int IDX_W   = 8;
    localparam int FRAC_W  = 20;

    localparam logic [CNT_W-1:0]   TIMEOUT_RST = 17'd60000;
    localparam logic [CNT_W-1:0]   MIN_RST     = 17'd100;
    localparam logic [CNT_W-1:0]   MAX_RST     = 17'd60000;
    localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd17994;
    localparam logic [DIST_W-1:0]  DIST_MAX    = 12'd4095;

    localparam logic [IDX_W-1:0] REG_TIMEOUT   = 8'd0;
    localparam logic [IDX_W-1:0] REG_MIN_PULSE = 8'd1;
    localparam logic [IDX_W-1:0] REG_MAX_PULSE = 8'd2;
    localparam logic [IDX_W-1:0] REG_SCALE     = 8'd3;

    localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
    localparam logic [STAT_W-1:0] ST_RISE_TIMEOUT = 3'd1;
    localparam logic [STAT_W-1:0] ST_FALL_TIMEOUT = 3'd2;
    localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 3'd3;
    localparam logic [STAT_W-1:0] ST_READ_FAULT   = 3'd4;

    typedef struct packed {
        logic cmd;
        logic echo_level;
        logic read_fault;
    } uer_in_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic [DIST_W-1:0] range_cm;
        logic [STAT_W-1:0] status;
    } uer_out_t;

    typedef struct packed {
        logic [CNT_W-1:0]   timeout_ticks;
        logic [CNT_W-1:0]   min_pulse_ticks;
        logic [CNT_W-1:0]   max_pulse_ticks;
        logic [SCALE_W-1:0] scale_q20;
    } uer_cfg_t;

endpackage

// ----- hdl/uer_cfg.sv -----
module uer_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [uer_pkg::IDX_W-1:0]    wr_index,
    input  logic [uer_pkg::CNT_W-1:0]    wr_data,
    output uer_pkg::uer_cfg_t            cfg
);
    import uer_pkg::*;

    uer_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.min_pulse_ticks <= MIN_RST;
            cfg_reg.max_pulse_ticks <= MAX_RST;
            cfg_reg.scale_q20       <= SCALE_RST;
        end
        else if (wr_en)
        begin
            // indexes beyond the list are dropped
            unique case (wr_index)
                REG_TIMEOUT:   cfg_reg.timeout_ticks <= wr_data;
                REG_MIN_PULSE: cfg_reg.min_pulse_ticks <= wr_data;
                REG_MAX_PULSE: cfg_reg.max_pulse_ticks <= wr_data;
                REG_SCALE:     cfg_reg.scale_q20 <= wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/uer_core.sv -----
module uer_core #(
    parameter int TRIG_LOW_TICKS  = uer_pkg::TRIG_LOW_TICKS_DEF,
    parameter int TRIG_HIGH_TICKS = uer_pkg::TRIG_HIGH_TICKS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  uer_pkg::uer_in_t   item,
    input  uer_pkg::uer_cfg_t  cfg,
    output uer_pkg::uer_out_t  result
);
    import uer_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_TRIG_LOW   = 3'd1;
    localparam logic [2:0] PH_TRIG_HIGH  = 3'd2;
    localparam logic [2:0] PH_WAIT_RISE  = 3'd3;
    localparam logic [2:0] PH_COUNT_HIGH = 3'd4;

    localparam logic [CNT_W-1:0] LOW_LAST  = CNT_W'(TRIG_LOW_TICKS);
    localparam logic [CNT_W-1:0] HIGH_LAST = CNT_W'(TRIG_HIGH_TICKS);
    localparam int PROD_W = CNT_W + 1 + SCALE_W;

    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [2:0]             phase_eff;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W:0]         pulse;
    logic [PROD_W-1:0]      product;
    logic [DIST_W-1:0]      dist_sat;
    logic                   in_window;
    uer_out_t               res;

    assign count_inc = count_reg + 1'b1;
    assign pulse     = {1'b0, count_reg} + 1'b1;
    assign product   = PROD_W'(pulse) * PROD_W'(cfg.scale_q20);
    // saturate when anything above the 12 result bits is set
    assign dist_sat  = (product[PROD_W-1:FRAC_W+DIST_W] != '0) ? DIST_MAX
                                                               : product[FRAC_W+DIST_W-1:FRAC_W];
    assign in_window = (pulse >= {1'b0, cfg.min_pulse_ticks}) &&
                       (pulse <= {1'b0, cfg.max_pulse_ticks});
    // unused codes behave as idle
    assign phase_eff = (phase_reg > PH_COUNT_HIGH) ? PH_IDLE : phase_reg;

    always_comb
    begin
        phase_next = phase_eff;
        count_next = (phase_reg > PH_COUNT_HIGH) ? '0 : count_reg;
        res        = '0;
        if (item.cmd)
        begin
            res.busy_res = 1'b1;
            if (phase_eff == PH_IDLE)
            begin
                phase_next = PH_TRIG_LOW;
                count_next = '0;
            end
            else
            begin
                res.trigger_level = (phase_eff == PH_TRIG_HIGH);
            end
        end
        else
        begin
            unique case (phase_eff)
                PH_TRIG_LOW:
                begin
                    res.busy_res = 1'b1;
                    count_next   = count_inc;
                    if (count_inc >= LOW_LAST)
                    begin
                        phase_next = PH_TRIG_HIGH;
                        count_next = '0;
                    end
                end
                PH_TRIG_HIGH:
                begin
                    res.busy_res      = 1'b1;
                    res.trigger_level = 1'b1;
                    count_next        = count_inc;
                    if (count_inc >= HIGH_LAST)
                    begin
                        phase_next = PH_WAIT_RISE;
                        count_next = '0;
                    end
                end
                PH_WAIT_RISE:
                begin
                    priority if (item.read_fault)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_READ_FAULT;
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                    end
                    else if (item.echo_level)
                    begin
                        res.busy_res = 1'b1;
                        phase_next   = PH_COUNT_HIGH;
                        count_next   = '0;
                    end
                    else if (count_reg >= cfg.timeout_ticks)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_RISE_TIMEOUT;
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                    end
                    else
                    begin
                        res.busy_res = 1'b1;
                        count_next   = count_inc;
                    end
                end
                PH_COUNT_HIGH:
                begin
                    priority if (item.read_fault)
                    begin
                        res.done_res = 1'b1;
                        res.status   = ST_READ_FAULT;
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                    end
                    else if (item.echo_level)
                    begin
                        if (count_reg >= cfg.timeout_ticks)
                        begin
                            res.done_res = 1'b1;
                            res.status   = ST_FALL_TIMEOUT;
                            phase_next   = PH_IDLE;
                            count_next   = '0;
                        end
                        else
                        begin
                            res.busy_res = 1'b1;
                            count_next   = count_inc;
                        end
                    end
                    else
                    begin
                        res.done_res = 1'b1;
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                        if (in_window)
                            res.range_cm = dist_sat;
                        else
                            res.status = ST_OUT_OF_RANGE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    assign result = res;

endmodule

// ----- hdl/ultrasonic_echo_ranger_unit.sv -----
// A word accepted into the input register steps the core and its result is captured in the result
// register once that register is free or being taken; a stalled result can hold the word in between.
// Throughput: one word per cycle while the result is not stalled; the phase/count update, window compare and
// 18x16 scale multiply all sit between the input register and result register.
// A stalled result holds its register; the input register takes one more word, then stalls.
// Reset clears the phase, tick count and both stage valids, and loads default config.
module ultrasonic_echo_ranger_unit #(
    parameter int TRIG_LOW_TICKS  = uer_pkg::TRIG_LOW_TICKS_DEF,
    parameter int TRIG_HIGH_TICKS = uer_pkg::TRIG_HIGH_TICKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  uer_pkg::uer_in_t             in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output uer_pkg::uer_out_t            out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [uer_pkg::IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CNT_W-1:0]    cfg_data
);
    import uer_pkg::*;

    logic      in_vld_reg;
    uer_in_t   in_word_reg;
    logic      out_vld_reg;
    uer_out_t  out_word_reg;
    logic      advance;
    uer_cfg_t  cfg;
    uer_out_t  result;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    uer_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    uer_core #(
        .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
        .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_word_reg),
        .cfg    (cfg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
        if (advance)
            out_word_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

endmodule
